// ===== src/gaas_pkg.sv =====
// Shared constants, status codes and control types of the glyph atlas shelf allocator.
package gaas_pkg;

   localparam int PAGE_SIDE_DEF    = 256;
   localparam int MAX_PAGES_DEF    = 64;
   localparam int SIZE_CLASSES_DEF = 4;

   localparam int WIDTH_W  = 9;
   localparam int HEIGHT_W = 8;
   localparam int PAGE_W   = 6;
   localparam int POS_X_W  = 9;
   localparam int POS_Y_W  = 8;
   localparam int STATUS_W = 2;

   localparam int CUR_X_W    = 9;
   localparam int CUR_Y_W    = 10;
   localparam int ROWH_W     = 12;
   localparam int SUM_W      = 14;
   localparam int CLASS_BASE = 16;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [STATUS_W-1:0] {
      ST_PLACED   = 2'd0,
      ST_TOO_TALL = 2'd1,
      ST_NO_PAGE  = 2'd2
   } gaas_status_type;

   typedef struct packed {
      logic            upd;
      logic            take_page;
      gaas_status_type status;
   } gaas_ctl_type;

endpackage

// ===== src/gaas_place.sv =====
// Size class selection and shelf placement for one glyph against the class state.
module gaas_place #(
   parameter int PAGE_SIDE    = gaas_pkg::PAGE_SIDE_DEF,
   parameter int MAX_PAGES    = gaas_pkg::MAX_PAGES_DEF,
   parameter int SIZE_CLASSES = gaas_pkg::SIZE_CLASSES_DEF,
   localparam int CNT_W       = $clog2(MAX_PAGES + 1),
   localparam int CLS_W       = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1
) (
   input  logic [gaas_pkg::WIDTH_W-1:0]  glyph_width,
   input  logic [gaas_pkg::HEIGHT_W-1:0] glyph_height,
   input  logic [SIZE_CLASSES-1:0]       has_page,
   input  logic [CNT_W-1:0]              class_page [SIZE_CLASSES],
   input  logic [gaas_pkg::CUR_X_W-1:0]  cur_x [SIZE_CLASSES],
   input  logic [gaas_pkg::CUR_Y_W-1:0]  cur_y [SIZE_CLASSES],
   input  logic [CNT_W-1:0]              pages_used,
   output gaas_pkg::gaas_ctl_type        ctl,
   output logic [CLS_W-1:0]              cls,
   output logic [CNT_W-1:0]              page,
   output logic [gaas_pkg::CUR_X_W-1:0]  pos_x,
   output logic [gaas_pkg::CUR_Y_W-1:0]  pos_y,
   output logic [gaas_pkg::CUR_X_W-1:0]  next_x
);

   localparam int SUM_W = gaas_pkg::SUM_W;
   localparam int CX_W  = gaas_pkg::CUR_X_W;

   logic                        found;
   logic [gaas_pkg::ROWH_W-1:0] rowh;
   logic                        has;
   logic [CX_W:0]               sum_x;
   logic                        wrap;
   logic [SUM_W-1:0]            cy_row;
   logic                        need_new;
   logic                        exhausted;
   logic                        restart;
   logic [CX_W:0]               nx;
   logic [CX_W+1:0]             nx_inc;

   // Lowest class whose row height exceeds the glyph height wins.
   always_comb begin
      found = 1'b0;
      cls   = '0;
      for (int i = SIZE_CLASSES - 1; i >= 0; i--) begin
         if (gaas_pkg::ROWH_W'(glyph_height) <
             (gaas_pkg::ROWH_W'(gaas_pkg::CLASS_BASE) << i)) begin
            found = 1'b1;
            cls   = CLS_W'(i);
         end
      end
   end

   assign rowh  = gaas_pkg::ROWH_W'(gaas_pkg::CLASS_BASE) << cls;
   assign has   = has_page[cls];
   assign sum_x = {1'b0, cur_x[cls]} + {1'b0, glyph_width};
   assign wrap  = has && (SUM_W'(sum_x) > SUM_W'(PAGE_SIDE));

   // Drop to the next shelf when the glyph runs past the right edge.
   assign cy_row = SUM_W'(cur_y[cls]) + (wrap ? (SUM_W'(rowh) + SUM_W'(1)) : '0);

   assign need_new  = !has ||
                      ((cy_row + SUM_W'(rowh) + SUM_W'(1)) > SUM_W'(PAGE_SIDE));
   assign exhausted = pages_used >= CNT_W'(MAX_PAGES);
   assign restart   = need_new || wrap;

   always_comb begin
      ctl.upd       = 1'b0;
      ctl.take_page = 1'b0;
      ctl.status    = gaas_pkg::ST_PLACED;
      if (!found) begin
         ctl.status = gaas_pkg::ST_TOO_TALL;
      end else if (need_new && exhausted) begin
         ctl.status = gaas_pkg::ST_NO_PAGE;
      end else begin
         ctl.upd       = 1'b1;
         ctl.take_page = need_new;
      end
   end

   assign page  = need_new ? pages_used : class_page[cls];
   assign pos_x = restart ? '0 : cur_x[cls];
   assign pos_y = need_new ? '0 : cy_row[gaas_pkg::CUR_Y_W-1:0];

   // Advance past the glyph plus one texel gap, saturating the cursor.
   assign nx     = restart ? {1'b0, glyph_width} : sum_x;
   assign nx_inc = {1'b0, nx} + (CX_W+2)'(1);
   assign next_x = nx_inc[CX_W+1:CX_W] != 2'b00 ? {CX_W{1'b1}} : nx_inc[CX_W-1:0];

endmodule

// ===== src/glyph_atlas_shelf_allocator.sv =====
// Top level of the glyph atlas shelf allocator.
// Each request item carries a glyph width and height; each takes exactly one response item
// with the page number, top-left position and a status (placed, too tall, or no free page).
// The block sustains one item per clock: an item is held in the input register, is placed
// by the combinational class select and shelf logic, and lands in the response register;
// class state updates in the same cycle as the result is registered. Throughput drops only
// while the response side holds tready low.
module glyph_atlas_shelf_allocator #(
   parameter int PAGE_SIDE    = gaas_pkg::PAGE_SIDE_DEF,
   parameter int MAX_PAGES    = gaas_pkg::MAX_PAGES_DEF,
   parameter int SIZE_CLASSES = gaas_pkg::SIZE_CLASSES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [8:0] glyph_width, [16:9] glyph_height, [23:17] zero
   input  logic [gaas_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [5:0] page_number, [14:6] pos_x, [22:15] pos_y, [23] zero
   output logic [gaas_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [1:0] status
   output logic [gaas_pkg::STATUS_W-1:0]     rsp_tuser
);

   localparam int CNT_W = $clog2(MAX_PAGES + 1);
   localparam int CLS_W = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
   localparam int WW    = gaas_pkg::WIDTH_W;
   localparam int HW    = gaas_pkg::HEIGHT_W;
   localparam int PW    = gaas_pkg::PAGE_W;
   localparam int XW    = gaas_pkg::POS_X_W;
   localparam int YW    = gaas_pkg::POS_Y_W;

   logic                         s1_vld_ff;
   logic [WW-1:0]                s1_w_ff;
   logic [HW-1:0]                s1_h_ff;

   logic [SIZE_CLASSES-1:0]      has_ff;
   logic [CNT_W-1:0]             page_ff [SIZE_CLASSES];
   logic [gaas_pkg::CUR_X_W-1:0] cx_ff [SIZE_CLASSES];
   logic [gaas_pkg::CUR_Y_W-1:0] cy_ff [SIZE_CLASSES];
   logic [CNT_W-1:0]             used_ff;

   logic                         rsp_vld_ff;
   logic [gaas_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [gaas_pkg::RSP_DATA_W-1:0] rsp_data_in;
   logic [gaas_pkg::STATUS_W-1:0]   rsp_user_ff;

   gaas_pkg::gaas_ctl_type       ctl;
   logic [CLS_W-1:0]             cls;
   logic [CNT_W-1:0]             page;
   logic [gaas_pkg::CUR_X_W-1:0] pos_x;
   logic [gaas_pkg::CUR_Y_W-1:0] pos_y;
   logic [gaas_pkg::CUR_X_W-1:0] next_x;
   logic [CNT_W+PW-1:0]          page_ext;
   logic                         advance;
   logic                         placed;

   gaas_place #(
      .PAGE_SIDE    (PAGE_SIDE),
      .MAX_PAGES    (MAX_PAGES),
      .SIZE_CLASSES (SIZE_CLASSES)
   ) u_place (
      .glyph_width  (s1_w_ff),
      .glyph_height (s1_h_ff),
      .has_page     (has_ff),
      .class_page   (page_ff),
      .cur_x        (cx_ff),
      .cur_y        (cy_ff),
      .pages_used   (used_ff),
      .ctl          (ctl),
      .cls          (cls),
      .page         (page),
      .pos_x        (pos_x),
      .pos_y        (pos_y),
      .next_x       (next_x)
   );

   // Move the staged item into the response register unless the response is stalled.
   assign advance    = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || advance;

   assign placed   = ctl.status == gaas_pkg::ST_PLACED;
   assign page_ext = {{PW{1'b0}}, page};

   always_comb begin
      rsp_data_in = '0;
      if (placed) begin
         rsp_data_in[PW-1:0]          = page_ext[PW-1:0];
         rsp_data_in[PW+XW-1:PW]      = pos_x;
         rsp_data_in[PW+XW+YW-1:PW+XW] = pos_y[YW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         has_ff     <= '0;
         used_ff    <= '0;
         for (int i = 0; i < SIZE_CLASSES; i++) begin
            page_ff[i] <= '0;
            cx_ff[i]   <= '0;
            cy_ff[i]   <= '0;
         end
      end else begin
         if (req_tready) begin
            s1_vld_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
         if (advance && ctl.upd) begin
            cx_ff[cls] <= next_x;
            cy_ff[cls] <= pos_y;
            if (ctl.take_page) begin
               has_ff[cls]  <= 1'b1;
               page_ff[cls] <= page;
               used_ff      <= used_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_w_ff <= req_tdata[WW-1:0];
         s1_h_ff <= req_tdata[WW+HW-1:WW];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= ctl.status;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== src/gaas_checker.sv =====
// Port-level checks for the glyph atlas shelf allocator, bound to the top level.
module gaas_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gaas_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [gaas_pkg::STATUS_W-1:0]   rsp_tuser
);

   // Only the three defined status codes go out.
   a_status_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == gaas_pkg::ST_PLACED ||
                      rsp_tuser == gaas_pkg::ST_TOO_TALL ||
                      rsp_tuser == gaas_pkg::ST_NO_PAGE))
      else $error("unknown status on response");

   // A rejected glyph reports page and position as zero.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != gaas_pkg::ST_PLACED) |-> rsp_tdata == '0)
      else $error("rejected glyph carries nonzero placement");

   // No response appears without an earlier accepted request.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid && !(req_tvalid && req_tready)) |=> ##1 !$rose(rsp_tvalid))
      else $error("response without a request");

   // A stalled response holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) &&
                                       $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind glyph_atlas_shelf_allocator gaas_checker u_gaas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/sv/tb_glyph_atlas_shelf_allocator.sv =====
// Self-checking testbench for the glyph atlas shelf allocator.
`timescale 1ns / 1ps

module tb_glyph_atlas_shelf_allocator;

   localparam int CURSOR_X_LIMIT = (1 << gaas_pkg::CUR_X_W) - 1;
   localparam int DUT_LATENCY    = 2;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int RANDOM_ITEMS   = 650;

   typedef struct packed {
      logic [gaas_pkg::PAGE_W-1:0]  page;
      logic [gaas_pkg::POS_X_W-1:0] x;
      logic [gaas_pkg::POS_Y_W-1:0] y;
      gaas_pkg::gaas_status_type    status;
   } placement_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [gaas_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [gaas_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [gaas_pkg::STATUS_W-1:0]   rsp_tuser;

   // Shelf state mirrored from the block's behavior
   bit                           shelf_has_page [gaas_pkg::SIZE_CLASSES_DEF];
   logic [gaas_pkg::PAGE_W-1:0]  shelf_page     [gaas_pkg::SIZE_CLASSES_DEF];
   logic [gaas_pkg::CUR_X_W-1:0] shelf_x        [gaas_pkg::SIZE_CLASSES_DEF];
   logic [gaas_pkg::CUR_Y_W-1:0] shelf_y        [gaas_pkg::SIZE_CLASSES_DEF];
   logic [6:0]                   pages_taken;

   placement_type placement_q[$];
   int            mismatch_count;
   bit            req_gaps_on;
   bit            rsp_gaps_on;
   int            rsp_hold_left;

   glyph_atlas_shelf_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Place one glyph in the mirrored shelves and return the expected result.
   function automatic placement_type place_glyph(
      input logic [gaas_pkg::WIDTH_W-1:0]  w,
      input logic [gaas_pkg::HEIGHT_W-1:0] h);
      placement_type r;
      int            cls;
      int            rowh;
      int            cx;
      int            cy;
      int            nx;
      int            pg;
      bit            found;
      bit            need_page;
      r.page   = '0;
      r.x      = '0;
      r.y      = '0;
      r.status = gaas_pkg::ST_TOO_TALL;
      found    = 1'b0;
      cls      = 0;
      rowh     = 0;
      for (int i = 0; i < gaas_pkg::SIZE_CLASSES_DEF; i++) begin
         if (!found && int'(h) < (gaas_pkg::CLASS_BASE << i)) begin
            cls   = i;
            rowh  = gaas_pkg::CLASS_BASE << i;
            found = 1'b1;
         end
      end
      if (!found) return r;
      cx        = int'(shelf_x[cls]);
      cy        = int'(shelf_y[cls]);
      pg        = int'(shelf_page[cls]);
      nx        = int'(w);
      need_page = 1'b1;
      if (shelf_has_page[cls]) begin
         nx = cx + int'(w);
         if (nx > gaas_pkg::PAGE_SIDE_DEF) begin
            cx = 0;
            nx = int'(w);
            cy = cy + rowh + 1;
         end
         need_page = (cy + rowh + 1) > gaas_pkg::PAGE_SIDE_DEF;
      end
      if (need_page) begin
         // a refused page also drops any pending row move
         if (int'(pages_taken) >= gaas_pkg::MAX_PAGES_DEF) begin
            r.status = gaas_pkg::ST_NO_PAGE;
            return r;
         end
         pg                  = int'(pages_taken);
         pages_taken         = pages_taken + 7'd1;
         cx                  = 0;
         cy                  = 0;
         nx                  = int'(w);
         shelf_has_page[cls] = 1'b1;
         shelf_page[cls]     = gaas_pkg::PAGE_W'(pg);
      end
      r.page   = gaas_pkg::PAGE_W'(pg);
      r.x      = gaas_pkg::POS_X_W'(cx);
      r.y      = gaas_pkg::POS_Y_W'(cy);
      r.status = gaas_pkg::ST_PLACED;
      nx = nx + 1;
      if (nx > CURSOR_X_LIMIT) nx = CURSOR_X_LIMIT;
      shelf_x[cls] = gaas_pkg::CUR_X_W'(nx);
      shelf_y[cls] = gaas_pkg::CUR_Y_W'(cy);
      return r;
   endfunction

   // Mostly no gap, some short ones, a few long ones.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [gaas_pkg::HEIGHT_W-1:0] random_height();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return gaas_pkg::HEIGHT_W'($urandom_range(0, 15));
      if (roll < 60) return gaas_pkg::HEIGHT_W'($urandom_range(16, 31));
      if (roll < 80) return gaas_pkg::HEIGHT_W'($urandom_range(32, 63));
      if (roll < 90) return gaas_pkg::HEIGHT_W'($urandom_range(64, 127));
      return gaas_pkg::HEIGHT_W'($urandom_range(128, 255));
   endfunction

   function automatic logic [gaas_pkg::WIDTH_W-1:0] random_width();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return gaas_pkg::WIDTH_W'($urandom_range(0, 48));
      if (roll < 95) return gaas_pkg::WIDTH_W'($urandom_range(49, 256));
      return gaas_pkg::WIDTH_W'($urandom_range(257, 511));
   endfunction

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endtask

   // Offer one glyph; valid stays high afterwards so the next item can follow directly.
   task automatic send_glyph(input logic [gaas_pkg::WIDTH_W-1:0]  w,
                             input logic [gaas_pkg::HEIGHT_W-1:0] h);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= gaas_pkg::REQ_DATA_W'({h, w});
      do @(posedge clock); while (!req_tready);
      placement_q.push_back(place_glyph(w, h));
   endtask

   // Drop valid and wait until every expected placement has come back.
   task automatic wait_drained();
      int waited;
      waited = 0;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (placement_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DUT_LATENCY + 2) @(posedge clock);
   endtask

   task automatic test_directed();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      send_glyph(9'd0,   8'd0);     // first glyph opens page 0
      send_glyph(9'd256, 8'd15);    // overflow moves to the next row
      send_glyph(9'd0,   8'd15);
      send_glyph(9'd511, 8'd16);    // wider than a page, cursor saturates
      send_glyph(9'd1,   8'd31);    // saturated cursor forces a new row
      send_glyph(9'd257, 8'd32);
      send_glyph(9'd100, 8'd63);
      send_glyph(9'd100, 8'd63);
      send_glyph(9'd100, 8'd63);
      send_glyph(9'd255, 8'd64);
      send_glyph(9'd255, 8'd127);   // second row does not fit, fresh page
      send_glyph(9'd10,  8'd128);   // too tall
      send_glyph(9'd511, 8'd255);
      send_glyph(9'd0,   8'd200);
      send_glyph(9'd256, 8'd0);
      send_glyph(9'd128, 8'd1);
      send_glyph(9'd127, 8'd2);
      send_glyph(9'd170, 8'd47);
      send_glyph(9'd85,  8'd96);
      send_glyph(9'd0,   8'd127);
      wait_drained();
   endtask

   task automatic test_random_shelves();
      for (int chunk = 0; chunk < 5; chunk++) begin
         req_gaps_on = (chunk != 1) && (chunk != 3);
         rsp_gaps_on = (chunk != 1) && (chunk != 2);
         for (int n = 0; n < RANDOM_ITEMS / 5; n++)
            send_glyph(random_width(), random_height());
      end
      wait_drained();
   endtask

   // Hold the receiver off while items keep coming, so the input side stalls.
   task automatic test_backpressure();
      req_gaps_on   = 1'b0;
      rsp_gaps_on   = 1'b1;
      rsp_hold_left = 150;
      for (int n = 0; n < 40; n++) send_glyph(random_width(), random_height());
      wait_drained();
   endtask

   task automatic test_page_exhaustion();
      int guard;
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      guard       = 0;
      // one wide tall glyph per page uses pages up quickly
      while (int'(pages_taken) < gaas_pkg::MAX_PAGES_DEF &&
             guard < 2 * gaas_pkg::MAX_PAGES_DEF) begin
         send_glyph(9'd200, gaas_pkg::HEIGHT_W'($urandom_range(64, 127)));
         guard++;
      end
      send_glyph(9'd200, 8'd100);
      send_glyph(9'd200, 8'd100);
      for (int n = 0; n < 30; n++)
         send_glyph(random_width(), gaas_pkg::HEIGHT_W'($urandom_range(0, 127)));
      wait_drained();
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      mismatch_count = 0;
      req_gaps_on    = 1'b0;
      rsp_gaps_on    = 1'b0;
      rsp_hold_left  = 0;
      pages_taken    = '0;
      for (int c = 0; c < gaas_pkg::SIZE_CLASSES_DEF; c++) begin
         shelf_has_page[c] = 1'b0;
         shelf_page[c]     = '0;
         shelf_x[c]        = '0;
         shelf_y[c]        = '0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_shelves();
      test_backpressure();
      test_page_exhaustion();
      if (mismatch_count == 0 && placement_q.size() == 0) begin
         $display("tb_glyph_atlas_shelf_allocator passed");
      end else begin
         $display("tb_glyph_atlas_shelf_allocator failed");
      end
      $finish;
   end

   // Receiver: random stall runs, plus a counted hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            rsp_tready <= (stall_left == 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      placement_type want;
      placement_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.page   = rsp_tdata[5:0];
         got.x      = rsp_tdata[14:6];
         got.y      = rsp_tdata[22:15];
         got.status = gaas_pkg::gaas_status_type'(rsp_tuser);
         if (placement_q.size() == 0) begin
            flag_error($sformatf("unexpected result page %0d x %0d y %0d status %0d",
                                 got.page, got.x, got.y, got.status));
         end else begin
            want = placement_q.pop_front();
            if (got.page !== want.page || got.x !== want.x || got.y !== want.y ||
                got.status !== want.status)
               flag_error($sformatf(
                  "mismatch: expected page %0d x %0d y %0d status %0d, got %0d %0d %0d %0d",
                  want.page, want.x, want.y, want.status,
                  got.page, got.x, got.y, got.status));
         end
      end
   end

   initial begin
      #20_000_000;
      $display("tb_glyph_atlas_shelf_allocator failed");
      $finish;
   end

endmodule
